FILE: src/lswc_pkg.sv
// Shared constants and types for the line segment window clipper.
// No dependencies; imported by line_segment_window_clipper.
package lswc_pkg;

    // Coordinate format: signed Q8.8
    localparam int COORD_BITS = 16;
    // Fraction bits of the clip parameters u1, u2 and t
    localparam int FRAC_BITS  = 16;
    // Magnitude of a coordinate difference
    localparam int MAG_W      = COORD_BITS;
    // Clip parameter width: holds 1.0 and one saturation code above it
    localparam int U_W        = FRAC_BITS + 1;
    // One quotient bit per divider stage
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int PROD_W     = U_W + 1 + COORD_BITS + 1;
    localparam int NUM_EDGES  = 4;

    localparam logic [U_W-1:0] U_ZERO = '0;
    localparam logic [U_W-1:0] U_ONE  = U_W'(1) << FRAC_BITS;

    // Register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;

endpackage

FILE: src/line_segment_window_clipper.sv
// Liang-Barsky segment clipper against a configurable window, top level.
// Depends on lswc_pkg (constants and coordinate types).
//
// Usage:
//   Write the four window edges through cfg_we / cfg_index / cfg_wdata
//   (0 left, 1 bottom, 2 right, 3 top, signed Q8.8) while no segment is
//   in flight. Segments enter on the s_ valid/ready channel, one word per
//   segment; each produces exactly one result word on the m_ channel.
//   Throughput: one segment per cycle while the output is not stalled by
//   m_ready. The restoring divider yields one quotient bit of each edge
//   parameter per stage and is followed by the min/max, multiply and add
//   stages.
//   The whole pipeline advances together: when the output word waits on
//   m_ready, every stage holds and s_ready drops; nothing is lost or
//   repeated. Bubbles travel as words with a cleared valid bit.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   window 2.0..4.0 on both axes.
module line_segment_window_clipper (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  lswc_pkg::coord_t       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lswc_pkg::coord_t       s_start_x,
    input  lswc_pkg::coord_t       s_start_y,
    input  lswc_pkg::coord_t       s_end_x,
    input  lswc_pkg::coord_t       s_end_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_visible,
    output logic                   m_wholly_inside,
    output lswc_pkg::coord_t       m_clipped_start_x,
    output lswc_pkg::coord_t       m_clipped_start_y,
    output lswc_pkg::coord_t       m_clipped_end_x,
    output lswc_pkg::coord_t       m_clipped_end_y
);
    import lswc_pkg::*;

    typedef struct packed {
        logic                                valid;
        logic                                reject;
        logic [NUM_EDGES-1:0]                entry;
        logic [NUM_EDGES-1:0]                leave;
        logic [NUM_EDGES-1:0]                sat;
        coord_t                              sx;
        coord_t                              sy;
        coord_t                              ex;
        coord_t                              ey;
        diff_t                               dx;
        diff_t                               dy;
        logic [NUM_EDGES-1:0][MAG_W-1:0]     dvs;
        logic [NUM_EDGES-1:0][MAG_W:0]       rem;
        logic [NUM_EDGES-1:0][U_W-1:0]       quo;
    } div_word_t;

    typedef struct packed {
        logic           valid;
        logic           reject;
        logic [U_W-1:0] u1;
        logic [U_W-1:0] u2;
        coord_t         sx;
        coord_t         sy;
        coord_t         ex;
        coord_t         ey;
        diff_t          dx;
        diff_t          dy;
    } span_word_t;

    typedef struct packed {
        logic                           valid;
        logic                           reject;
        logic                           wholly;
        coord_t                         sx;
        coord_t                         sy;
        coord_t                         ex;
        coord_t                         ey;
        logic signed [PROD_W-1:0]       p1x;
        logic signed [PROD_W-1:0]       p1y;
        logic signed [PROD_W-1:0]       p2x;
        logic signed [PROD_W-1:0]       p2y;
    } prod_word_t;

    coord_t     left_reg, bottom_reg, right_reg, top_reg;
    div_word_t  prep_reg, prep_next;
    div_word_t  div_reg  [DIV_STAGES];
    div_word_t  div_src  [DIV_STAGES];
    div_word_t  div_next [DIV_STAGES];
    logic [MAG_W:0] trial [DIV_STAGES][NUM_EDGES];
    span_word_t span_reg, span_next;
    prod_word_t prod_reg, prod_next;
    logic       out_valid_reg;
    logic       advance;
    diff_t      pv [NUM_EDGES];
    diff_t      qv [NUM_EDGES];
    diff_t      pa [NUM_EDGES];
    diff_t      qa [NUM_EDGES];
    logic [U_W-1:0] tm [NUM_EDGES];
    logic signed [PROD_W-1:0] off1x, off1y, off2x, off2y;

    // Whole pipeline moves as one when the output slot is free or taken
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = out_valid_reg;

    // Window registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= coord_t'(512);
            bottom_reg <= coord_t'(512);
            right_reg  <= coord_t'(1024);
            top_reg    <= coord_t'(1024);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_wdata;
                REG_BOTTOM: bottom_reg <= cfg_wdata;
                REG_RIGHT:  right_reg  <= cfg_wdata;
                REG_TOP:    top_reg    <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Form p and q per edge, classify edges, load divider operands
    always_comb begin
        prep_next       = '0;
        prep_next.valid = s_valid;
        prep_next.sx    = s_start_x;
        prep_next.sy    = s_start_y;
        prep_next.ex    = s_end_x;
        prep_next.ey    = s_end_y;
        prep_next.dx    = diff_t'(s_end_x) - diff_t'(s_start_x);
        prep_next.dy    = diff_t'(s_end_y) - diff_t'(s_start_y);
        pv[0] = -prep_next.dx;
        pv[1] = prep_next.dx;
        pv[2] = -prep_next.dy;
        pv[3] = prep_next.dy;
        qv[0] = diff_t'(s_start_x) - diff_t'(left_reg);
        qv[1] = diff_t'(right_reg) - diff_t'(s_start_x);
        qv[2] = diff_t'(s_start_y) - diff_t'(bottom_reg);
        qv[3] = diff_t'(top_reg) - diff_t'(s_start_y);
        for (int i = 0; i < NUM_EDGES; i++) begin
            pa[i] = pv[i][COORD_BITS] ? -pv[i] : pv[i];
            qa[i] = qv[i][COORD_BITS] ? -qv[i] : qv[i];
            // negative t on an exit edge (forcing u2 below u1), or p = 0 with q < 0, rejects
            if (!pv[i][COORD_BITS] && qv[i][COORD_BITS]) begin
                prep_next.reject = 1'b1;
            end
            prep_next.entry[i] = pv[i][COORD_BITS] && qv[i][COORD_BITS];
            prep_next.leave[i] = (pv[i] != '0) && !pv[i][COORD_BITS]
                                 && !qv[i][COORD_BITS];
            // quotient at or above 2.0 saturates
            prep_next.sat[i]   = {1'b0, qa[i][MAG_W-1:0]} >= {pa[i][MAG_W-1:0], 1'b0};
            prep_next.dvs[i]   = pa[i][MAG_W-1:0];
            prep_next.rem[i]   = {1'b0, qa[i][MAG_W-1:0]};
        end
    end

    // Restoring divider: one quotient bit per stage, MSB first
    always_comb begin
        div_src[0] = prep_reg;
        for (int j = 1; j < DIV_STAGES; j++) begin
            div_src[j] = div_reg[j-1];
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            div_next[j] = div_src[j];
            for (int i = 0; i < NUM_EDGES; i++) begin
                trial[j][i] = (j == 0) ? div_src[j].rem[i]
                                       : {div_src[j].rem[i][MAG_W-1:0], 1'b0};
                if (trial[j][i] >= {1'b0, div_src[j].dvs[i]}) begin
                    div_next[j].rem[i] = trial[j][i] - {1'b0, div_src[j].dvs[i]};
                    div_next[j].quo[i] = {div_src[j].quo[i][U_W-2:0], 1'b1};
                end else begin
                    div_next[j].rem[i] = trial[j][i];
                    div_next[j].quo[i] = {div_src[j].quo[i][U_W-2:0], 1'b0};
                end
            end
        end
    end

    // Raise u1 over entry edges, lower u2 over exit edges
    always_comb begin
        span_next.valid  = div_reg[DIV_STAGES-1].valid;
        span_next.sx     = div_reg[DIV_STAGES-1].sx;
        span_next.sy     = div_reg[DIV_STAGES-1].sy;
        span_next.ex     = div_reg[DIV_STAGES-1].ex;
        span_next.ey     = div_reg[DIV_STAGES-1].ey;
        span_next.dx     = div_reg[DIV_STAGES-1].dx;
        span_next.dy     = div_reg[DIV_STAGES-1].dy;
        span_next.u1     = U_ZERO;
        span_next.u2     = U_ONE;
        for (int i = 0; i < NUM_EDGES; i++) begin
            tm[i] = div_reg[DIV_STAGES-1].sat[i] ? '1 : div_reg[DIV_STAGES-1].quo[i];
            if (div_reg[DIV_STAGES-1].entry[i] && tm[i] > span_next.u1) begin
                span_next.u1 = tm[i];
            end
            if (div_reg[DIV_STAGES-1].leave[i] && tm[i] < span_next.u2) begin
                span_next.u2 = tm[i];
            end
        end
        span_next.reject = div_reg[DIV_STAGES-1].reject || (span_next.u1 > span_next.u2);
    end

    // Multiply the clip parameters by the direction
    always_comb begin
        prod_next.valid  = span_reg.valid;
        prod_next.reject = span_reg.reject;
        prod_next.wholly = (span_reg.u1 == U_ZERO) && (span_reg.u2 == U_ONE);
        prod_next.sx     = span_reg.sx;
        prod_next.sy     = span_reg.sy;
        prod_next.ex     = span_reg.ex;
        prod_next.ey     = span_reg.ey;
        prod_next.p1x    = $signed({1'b0, span_reg.u1}) * span_reg.dx;
        prod_next.p1y    = $signed({1'b0, span_reg.u1}) * span_reg.dy;
        prod_next.p2x    = $signed({1'b0, span_reg.u2}) * span_reg.dx;
        prod_next.p2y    = $signed({1'b0, span_reg.u2}) * span_reg.dy;
    end

    assign off1x = prod_reg.p1x >>> FRAC_BITS;
    assign off1y = prod_reg.p1y >>> FRAC_BITS;
    assign off2x = prod_reg.p2x >>> FRAC_BITS;
    assign off2y = prod_reg.p2y >>> FRAC_BITS;

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_reg.valid <= 1'b0;
            for (int j = 0; j < DIV_STAGES; j++) begin
                div_reg[j].valid <= 1'b0;
            end
            span_reg.valid <= 1'b0;
            prod_reg.valid <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (advance) begin
            prep_reg <= prep_next;
            for (int j = 0; j < DIV_STAGES; j++) begin
                div_reg[j] <= div_next[j];
            end
            span_reg      <= span_next;
            prod_reg      <= prod_next;
            out_valid_reg <= prod_reg.valid;
            if (prod_reg.reject) begin
                m_visible         <= 1'b0;
                m_wholly_inside   <= 1'b0;
                m_clipped_start_x <= prod_reg.sx;
                m_clipped_start_y <= prod_reg.sy;
                m_clipped_end_x   <= prod_reg.ex;
                m_clipped_end_y   <= prod_reg.ey;
            end else begin
                m_visible         <= 1'b1;
                m_wholly_inside   <= prod_reg.wholly;
                m_clipped_start_x <= prod_reg.sx + off1x[COORD_BITS-1:0];
                m_clipped_start_y <= prod_reg.sy + off1y[COORD_BITS-1:0];
                m_clipped_end_x   <= prod_reg.sx + off2x[COORD_BITS-1:0];
                m_clipped_end_y   <= prod_reg.sy + off2y[COORD_BITS-1:0];
            end
        end
    end

    // A kept span is ordered
    assert property (@(posedge aclk) disable iff (!aresetn)
        span_reg.valid && !span_reg.reject |-> span_reg.u1 <= span_reg.u2)
        else $error("kept segment with u1 above u2");

    // A rejected result never claims to be wholly inside
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_visible |-> !m_wholly_inside)
        else $error("rejected segment flagged wholly inside");

    // A stall freezes the inner stages
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(span_reg) && $stable(prod_reg))
        else $error("pipeline moved during stall");

    // Reset empties the output slot
    assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg)
        else $error("output valid after reset");

endmodule
